### sv/vcs_pkg.sv
// Shared widths, register indexes and pipeline payload types of the velocity command smoother.
package vcs_pkg;

  // Field and datapath widths.
  localparam int VEL_WIDTH      = 16;
  localparam int PERIOD_WIDTH   = 16;
  localparam int LIM_WIDTH      = VEL_WIDTH - 1;
  localparam int ABS_WIDTH      = VEL_WIDTH;
  localparam int PROD_WIDTH     = ABS_WIDTH + LIM_WIDTH;
  localparam int QUO_WIDTH      = LIM_WIDTH;
  localparam int NUM_DIV        = QUO_WIDTH;
  localparam int FRONT_STAGES   = 4;
  localparam int NUM_STAGES     = FRONT_STAGES + NUM_DIV + 1;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = (PERIOD_WIDTH > LIM_WIDTH) ? PERIOD_WIDTH : LIM_WIDTH;
  localparam int IN_TDATA_WIDTH  = ((4 * VEL_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = ((2 * VEL_WIDTH + 7) / 8) * 8;
  localparam int OUT_TUSER_WIDTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEED_LIN = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ACCEL_LIN = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DECEL_LIN = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEED_ANG = CFG_IDX_WIDTH'(3);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ACCEL_ANG = CFG_IDX_WIDTH'(4);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DECEL_ANG = CFG_IDX_WIDTH'(5);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TICK      = CFG_IDX_WIDTH'(6);

  // Register values after reset.
  localparam logic [LIM_WIDTH-1:0]    LIM_RESET    = LIM_WIDTH'(4096);
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(6554);

  typedef logic signed [VEL_WIDTH-1:0] vel_t;
  typedef logic [LIM_WIDTH-1:0]        lim_t;
  typedef logic [ABS_WIDTH-1:0]        abs_t;
  typedef logic [PROD_WIDTH-1:0]       prod_t;
  typedef logic [PERIOD_WIDTH-1:0]     period_t;
  typedef logic [QUO_WIDTH-1:0]        quo_t;

  // Which allowed step the divider result replaces.
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_LIN,
    SEL_ANG
  } div_sel_e;

  typedef struct packed {
    lim_t    speed_lin;
    lim_t    accel_lin;
    lim_t    decel_lin;
    lim_t    speed_ang;
    lim_t    accel_ang;
    lim_t    decel_ang;
    period_t tick_period;
  } cfg_t;

  typedef struct packed {
    vel_t target_lin;
    vel_t target_ang;
    vel_t current_lin;
    vel_t current_ang;
  } in_item_t;

  // Per-axis context carried down the whole pipeline.
  typedef struct packed {
    vel_t tgt_lin;
    vel_t tgt_ang;
    vel_t cur_lin;
    vel_t cur_ang;
    logic neg_lin;
    logic neg_ang;
    abs_t abs_lin;
    abs_t abs_ang;
  } axis_t;

  // Payload of the divider stages.
  typedef struct packed {
    axis_t    ax;
    lim_t     step_lin;
    lim_t     step_ang;
    div_sel_e sel;
    abs_t     den;
    abs_t     rem;
    quo_t     num_lo;
    quo_t     quo;
  } div_t;

  typedef struct packed {
    vel_t command_lin;
    vel_t command_ang;
    logic lin_limited;
    logic ang_limited;
  } out_item_t;

endpackage

### sv/vcs_front.sv
// Front pipeline stages: target clamp, step limit choice, step scaling, cross products, divider set-up.
module vcs_front import vcs_pkg::*; (
  input  logic                    clk_i,
  input  logic [FRONT_STAGES-1:0] en_i,
  input  cfg_t                    cfg_i,
  input  in_item_t                item_i,
  output div_t                    out_o
);

  // Clamp a request to the symmetric speed limit.
  function automatic vel_t clamp_speed(input vel_t t, input lim_t lim);
    logic signed [VEL_WIDTH:0] tw;
    logic signed [VEL_WIDTH:0] lp;
    logic signed [VEL_WIDTH:0] ln;
    logic signed [VEL_WIDTH:0] r;
    tw = $signed({t[VEL_WIDTH-1], t});
    lp = $signed({2'b00, lim});
    ln = -lp;
    if (tw > 0) begin
      r = (tw < lp) ? tw : lp;
    end else begin
      r = (tw > ln) ? tw : ln;
    end
    return r[VEL_WIDTH-1:0];
  endfunction

  // Acceleration limit only when the step grows the request without a sign reversal.
  function automatic lim_t pick_limit(input vel_t cur, input vel_t tgt,
                                      input logic signed [VEL_WIDTH:0] inc,
                                      input lim_t acc, input lim_t dec);
    logic rev;
    logic grows;
    rev   = (cur < 0 && tgt > 0) || (cur > 0 && tgt < 0);
    grows = (inc > 0 && tgt > 0) || (inc < 0 && tgt < 0);
    return (!rev && grows) ? acc : dec;
  endfunction

  // Stage 1: clamp, step and its magnitude, limit selection.
  vel_t                      tl, ta;
  logic signed [VEL_WIDTH:0] inc_lin, inc_ang, mag_lin, mag_ang;
  axis_t                     ax1_d, ax1_q;
  lim_t                      lim_lin_q, lim_ang_q;

  always_comb begin
    tl      = clamp_speed(item_i.target_lin, cfg_i.speed_lin);
    ta      = clamp_speed(item_i.target_ang, cfg_i.speed_ang);
    inc_lin = $signed({tl[VEL_WIDTH-1], tl})
            - $signed({item_i.current_lin[VEL_WIDTH-1], item_i.current_lin});
    inc_ang = $signed({ta[VEL_WIDTH-1], ta})
            - $signed({item_i.current_ang[VEL_WIDTH-1], item_i.current_ang});
    mag_lin = inc_lin[VEL_WIDTH] ? -inc_lin : inc_lin;
    mag_ang = inc_ang[VEL_WIDTH] ? -inc_ang : inc_ang;
    ax1_d.tgt_lin = tl;
    ax1_d.tgt_ang = ta;
    ax1_d.cur_lin = item_i.current_lin;
    ax1_d.cur_ang = item_i.current_ang;
    ax1_d.neg_lin = inc_lin[VEL_WIDTH];
    ax1_d.neg_ang = inc_ang[VEL_WIDTH];
    ax1_d.abs_lin = mag_lin[ABS_WIDTH-1:0];
    ax1_d.abs_ang = mag_ang[ABS_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ax1_q     <= ax1_d;
      lim_lin_q <= pick_limit(item_i.current_lin, tl, inc_lin,
                              cfg_i.accel_lin, cfg_i.decel_lin);
      lim_ang_q <= pick_limit(item_i.current_ang, ta, inc_ang,
                              cfg_i.accel_ang, cfg_i.decel_ang);
    end
  end

  // Stage 2: allowed step per period, truncated to Q3.12.
  logic [LIM_WIDTH+PERIOD_WIDTH-1:0] raw_lin, raw_ang;
  axis_t                             ax2_q;
  lim_t                              step_lin2_q, step_ang2_q;

  assign raw_lin = lim_lin_q * cfg_i.tick_period;
  assign raw_ang = lim_ang_q * cfg_i.tick_period;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ax2_q       <= ax1_q;
      step_lin2_q <= raw_lin[LIM_WIDTH+PERIOD_WIDTH-1:PERIOD_WIDTH];
      step_ang2_q <= raw_ang[LIM_WIDTH+PERIOD_WIDTH-1:PERIOD_WIDTH];
    end
  end

  // Stage 3: cross products for the direction comparison.
  prod_t cross_lin_d, cross_ang_d, cross_lin_q, cross_ang_q;
  axis_t ax3_q;
  lim_t  step_lin3_q, step_ang3_q;

  assign cross_lin_d = ax2_q.abs_lin * step_ang2_q;
  assign cross_ang_d = ax2_q.abs_ang * step_lin2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ax3_q       <= ax2_q;
      step_lin3_q <= step_lin2_q;
      step_ang3_q <= step_ang2_q;
      cross_lin_q <= cross_lin_d;
      cross_ang_q <= cross_ang_d;
    end
  end

  // Stage 4: pick the overconstrained axis and load the divider operands.
  div_t  div_d, div_q;
  prod_t num;

  always_comb begin
    div_d.ax       = ax3_q;
    div_d.step_lin = step_lin3_q;
    div_d.step_ang = step_ang3_q;
    div_d.quo      = '0;
    if (cross_lin_q < cross_ang_q) begin
      div_d.sel = SEL_LIN;
      num       = cross_lin_q;
      div_d.den = ax3_q.abs_ang;
    end else if (ax3_q.abs_lin != '0) begin
      div_d.sel = SEL_ANG;
      num       = cross_ang_q;
      div_d.den = ax3_q.abs_lin;
    end else begin
      div_d.sel = SEL_NONE;
      num       = '0;
      div_d.den = '0;
    end
    div_d.rem    = num[PROD_WIDTH-1:QUO_WIDTH];
    div_d.num_lo = num[QUO_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      div_q <= div_d;
    end
  end

  assign out_o = div_q;

endmodule

### sv/vcs_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module vcs_div import vcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [NUM_DIV-1:0] en_i,
  input  logic               vld_i,
  input  div_t               in_i,
  output div_t               out_o
);

  div_t chain [NUM_DIV+1];

  assign chain[0] = in_i;

  // Each stage shifts in the next numerator bit and subtracts when it fits.
  for (genvar g = 0; g < NUM_DIV; g++) begin : g_step
    localparam int Bit = NUM_DIV - 1 - g;
    div_t                 stage_d, stage_q;
    logic [ABS_WIDTH:0]   trial, diff;

    always_comb begin
      stage_d = chain[g];
      trial   = {chain[g].rem, chain[g].num_lo[Bit]};
      diff    = trial - {1'b0, chain[g].den};
      if (!diff[ABS_WIDTH]) begin
        stage_d.rem      = diff[ABS_WIDTH-1:0];
        stage_d.quo[Bit] = 1'b1;
      end else begin
        stage_d.rem = trial[ABS_WIDTH-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g]) begin
        stage_q <= stage_d;
      end
    end

    assign chain[g+1] = stage_q;
  end

  assign out_o = chain[NUM_DIV];

  // A real division never sees a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i && out_o.sel != SEL_NONE |-> out_o.den != '0)
    else $error("divider received a zero divisor");

  // The final remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i && out_o.sel != SEL_NONE |-> out_o.rem < out_o.den)
    else $error("divider remainder not below divisor");

endmodule

### sv/vcs_back.sv
// Final stage: rescaled allowed steps, limited command and saturation into the output register.
module vcs_back import vcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      vld_i,
  input  div_t      in_i,
  output out_item_t out_o
);

  // Saturate to the signed command range.
  function automatic vel_t sat_vel(input logic signed [VEL_WIDTH:0] v);
    logic signed [VEL_WIDTH:0] hi;
    logic signed [VEL_WIDTH:0] lo;
    hi = $signed({2'b00, {LIM_WIDTH{1'b1}}});
    lo = $signed({2'b11, {LIM_WIDTH{1'b0}}});
    if (v > hi) begin
      return hi[VEL_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[VEL_WIDTH-1:0];
    end
    return v[VEL_WIDTH-1:0];
  endfunction

  lim_t                      fin_lin, fin_ang;
  logic signed [VEL_WIDTH:0] cur_lin_w, cur_ang_w, mv_lin, mv_ang;
  out_item_t                 res_d, res_q;

  // Route the quotient to the axis it rescales.
  always_comb begin
    fin_lin = in_i.step_lin;
    fin_ang = in_i.step_ang;
    case (in_i.sel)
      SEL_LIN: fin_lin = in_i.quo;
      SEL_ANG: fin_ang = in_i.quo;
      default: ;
    endcase
  end

  // An axis whose step exceeds its allowed step moves by exactly that step.
  always_comb begin
    cur_lin_w = $signed({in_i.ax.cur_lin[VEL_WIDTH-1], in_i.ax.cur_lin});
    cur_ang_w = $signed({in_i.ax.cur_ang[VEL_WIDTH-1], in_i.ax.cur_ang});
    mv_lin = in_i.ax.neg_lin ? cur_lin_w - $signed({2'b00, fin_lin})
                             : cur_lin_w + $signed({2'b00, fin_lin});
    mv_ang = in_i.ax.neg_ang ? cur_ang_w - $signed({2'b00, fin_ang})
                             : cur_ang_w + $signed({2'b00, fin_ang});
    res_d.lin_limited = in_i.ax.abs_lin > {1'b0, fin_lin};
    res_d.ang_limited = in_i.ax.abs_ang > {1'b0, fin_ang};
    res_d.command_lin = res_d.lin_limited ? sat_vel(mv_lin) : in_i.ax.tgt_lin;
    res_d.command_ang = res_d.ang_limited ? sat_vel(mv_ang) : in_i.ax.tgt_ang;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign out_o = res_q;

  // A rescaled linear step is strictly smaller than the one it replaces.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i && in_i.sel == SEL_LIN |-> in_i.quo < in_i.step_lin)
    else $error("linear rescale did not shrink the allowed step");

  // A rescaled angular step never grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i && in_i.sel == SEL_ANG |-> in_i.quo <= in_i.step_ang)
    else $error("angular rescale grew the allowed step");

endmodule

### sv/velocity_command_smoother_core.sv
// Top level of the velocity command smoother: configuration registers and pipeline flow control.
//
//  Channel   Direction  Transaction carries
//  s_axis    in         tdata: target_lin, target_ang, current_lin, current_ang
//  m_axis    out        tdata: command_lin, command_ang; tuser: lin_limited, ang_limited
//  cfg       in         one register write per cycle while cfg_we_i is high
//
// One transaction per cycle is taken unless a stalled output has backed the pipeline up to its
// input; each result passes through the front stages, the fifteen one-bit stages of the divider and the final stage.
// Reset clears the valid bits and loads the register defaults; no clearing pass is needed.
// Every stage holds its contents while the one after it is full and stalled, so bubbles
// close up and input is still taken while a result waits at the output.
module velocity_command_smoother_core import vcs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // target_lin [15:0], target_ang [31:16], current_lin [47:32], current_ang [63:48]
  input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // command_lin [15:0], command_ang [31:16]
  output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  // lin_limited [0], ang_limited [1]
  output logic [OUT_TUSER_WIDTH-1:0] m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_lin   <= LIM_RESET;
      cfg_q.accel_lin   <= LIM_RESET;
      cfg_q.decel_lin   <= LIM_RESET;
      cfg_q.speed_ang   <= LIM_RESET;
      cfg_q.accel_ang   <= LIM_RESET;
      cfg_q.decel_ang   <= LIM_RESET;
      cfg_q.tick_period <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPEED_LIN: cfg_q.speed_lin   <= cfg_data_i[LIM_WIDTH-1:0];
        REG_ACCEL_LIN: cfg_q.accel_lin   <= cfg_data_i[LIM_WIDTH-1:0];
        REG_DECEL_LIN: cfg_q.decel_lin   <= cfg_data_i[LIM_WIDTH-1:0];
        REG_SPEED_ANG: cfg_q.speed_ang   <= cfg_data_i[LIM_WIDTH-1:0];
        REG_ACCEL_ANG: cfg_q.accel_ang   <= cfg_data_i[LIM_WIDTH-1:0];
        REG_DECEL_ANG: cfg_q.decel_ang   <= cfg_data_i[LIM_WIDTH-1:0];
        REG_TICK:      cfg_q.tick_period <= cfg_data_i[PERIOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transaction.
  in_item_t item;

  assign item.target_lin  = s_axis_tdata[VEL_WIDTH-1:0];
  assign item.target_ang  = s_axis_tdata[2*VEL_WIDTH-1:VEL_WIDTH];
  assign item.current_lin = s_axis_tdata[3*VEL_WIDTH-1:2*VEL_WIDTH];
  assign item.current_ang = s_axis_tdata[4*VEL_WIDTH-1:3*VEL_WIDTH];

  // Valid bits and per-stage ready: a stage loads when empty or when its successor moves.
  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES:0]   rdy;

  assign rdy[NUM_STAGES] = m_axis_tready;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign vld_d = {vld_q[NUM_STAGES-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];

  // Datapath.
  div_t      front_out, div_out;
  out_item_t res;

  vcs_front u_front (
    .clk_i  (clk_i),
    .en_i   (rdy[FRONT_STAGES-1:0]),
    .cfg_i  (cfg_q),
    .item_i (item),
    .out_o  (front_out)
  );

  vcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (rdy[FRONT_STAGES +: NUM_DIV]),
    .vld_i  (vld_q[NUM_STAGES-2]),
    .in_i   (front_out),
    .out_o  (div_out)
  );

  vcs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (rdy[NUM_STAGES-1]),
    .vld_i  (vld_q[NUM_STAGES-2]),
    .in_i   (div_out),
    .out_o  (res)
  );

  // Pack the result transaction.
  assign m_axis_tdata = OUT_TDATA_WIDTH'({res.command_ang, res.command_lin});
  assign m_axis_tuser = {res.ang_limited, res.lin_limited};

  // Input is refused only when every stage is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q) && !m_axis_tready)
    else $error("input refused with room in the pipeline");

  // An accepted transaction always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule
